// ===== src/catmull_rom_path_sampler_defines.svh =====
// assertion macros shared by the path sampler modules
`ifndef CATMULL_ROM_PATH_SAMPLER_DEFINES_SVH
`define CATMULL_ROM_PATH_SAMPLER_DEFINES_SVH

// antecedent implies consequent in the same cycle, checked outside reset
`define CRPS_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// a condition that must never hold, checked outside reset
`define CRPS_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// ===== src/crps_pkg.sv =====
// types and constants of the path sampler
`timescale 1ns / 1ps
package crps_pkg;

   localparam int CW     = 20;
   localparam int STEPW  = 9;
   localparam int FRAC   = 16;
   localparam int QW     = 18;
   localparam int QDEPTH = 4;
   localparam int QAW    = 2;
   localparam int QCW    = 3;

   localparam logic [STEPW-1:0] STEP_RESET = 9'd128;
   localparam logic signed [CW-1:0] COORD_MAX = 20'sd524287;
   localparam logic signed [CW-1:0] COORD_MIN = -20'sd524288;

   typedef logic signed [CW-1:0] coord_type;

   // one unit of work for the back end: an echo or a segment
   typedef struct packed {
      logic            echo;
      logic            first;
      logic            path_end;
      logic            run_last;
      coord_type [3:0] px;
      coord_type [3:0] py;
   } cmd_type;

endpackage

// ===== src/crps_front.sv =====
// front end: waypoint history and segment classification
`timescale 1ns / 1ps
module crps_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic signed [crps_pkg::CW-1:0] x_coord,
   input  logic signed [crps_pkg::CW-1:0] y_coord,
   input  logic                         last_waypoint,
   input  logic                         q_room,
   output logic                         push0,
   output logic                         push1,
   output crps_pkg::cmd_type            cmd0,
   output crps_pkg::cmd_type            cmd1
);
   import crps_pkg::*;

   logic [1:0] cnt_ff, cnt_in;
   coord_type  hx_ff [3];
   coord_type  hy_ff [3];
   logic       accept;
   logic       seg_a;
   cmd_type    echo_cmd, a_cmd, b_cmd;

   assign req_tready = q_room;
   assign accept     = req_tvalid && q_room;
   assign seg_a      = (cnt_ff >= 2'd2);

   // candidate commands
   always_comb begin
      echo_cmd          = '0;
      echo_cmd.echo     = 1'b1;
      echo_cmd.first    = 1'b1;
      echo_cmd.path_end = last_waypoint;
      echo_cmd.run_last = 1'b1;
      echo_cmd.px[2]    = x_coord;
      echo_cmd.py[2]    = y_coord;

      a_cmd          = '0;
      a_cmd.run_last = !last_waypoint;
      a_cmd.px[0]    = (cnt_ff == 2'd2) ? hx_ff[1] : hx_ff[2];
      a_cmd.py[0]    = (cnt_ff == 2'd2) ? hy_ff[1] : hy_ff[2];
      a_cmd.px[1]    = hx_ff[1];
      a_cmd.py[1]    = hy_ff[1];
      a_cmd.px[2]    = hx_ff[0];
      a_cmd.py[2]    = hy_ff[0];
      a_cmd.px[3]    = x_coord;
      a_cmd.py[3]    = y_coord;

      b_cmd          = '0;
      b_cmd.path_end = 1'b1;
      b_cmd.run_last = 1'b1;
      b_cmd.px[0]    = (cnt_ff == 2'd1) ? hx_ff[0] : hx_ff[1];
      b_cmd.py[0]    = (cnt_ff == 2'd1) ? hy_ff[0] : hy_ff[1];
      b_cmd.px[1]    = hx_ff[0];
      b_cmd.py[1]    = hy_ff[0];
      b_cmd.px[2]    = x_coord;
      b_cmd.py[2]    = y_coord;
      b_cmd.px[3]    = x_coord;
      b_cmd.py[3]    = y_coord;
   end

   // select what goes into the queue
   always_comb begin
      push0 = 1'b0;
      push1 = 1'b0;
      cmd0  = b_cmd;
      cmd1  = b_cmd;
      if (cnt_ff == 2'd0) begin
         push0 = accept;
         cmd0  = echo_cmd;
      end else if (seg_a) begin
         push0 = accept;
         push1 = accept && last_waypoint;
         cmd0  = a_cmd;
      end else begin
         push0 = accept && last_waypoint;
      end
   end

   // received count
   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         if (last_waypoint) begin
            cnt_in = 2'd0;
         end else if (cnt_ff != 2'd3) begin
            cnt_in = cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // history shift, cleared at end of path
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            hx_ff[i] <= '0;
            hy_ff[i] <= '0;
         end
      end else if (accept) begin
         if (last_waypoint) begin
            for (int i = 0; i < 3; i++) begin
               hx_ff[i] <= '0;
               hy_ff[i] <= '0;
            end
         end else begin
            hx_ff[2] <= hx_ff[1];
            hy_ff[2] <= hy_ff[1];
            hx_ff[1] <= hx_ff[0];
            hy_ff[1] <= hy_ff[0];
            hx_ff[0] <= x_coord;
            hy_ff[0] <= y_coord;
         end
      end
   end

endmodule

// ===== src/crps_queue.sv =====
// command queue between front and back, two writes and one read per cycle
`timescale 1ns / 1ps
`include "catmull_rom_path_sampler_defines.svh"
module crps_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push0,
   input  logic              push1,
   input  crps_pkg::cmd_type cmd0,
   input  crps_pkg::cmd_type cmd1,
   input  logic              pop,
   output crps_pkg::cmd_type head,
   output logic              not_empty,
   output logic              room2
);
   import crps_pkg::*;

   cmd_type              mem_ff [QDEPTH];
   logic [QAW-1:0]       wp_ff, wp_in, rp_ff, rp_in;
   logic [QCW-1:0]       cnt_ff, cnt_in;
   logic [QAW-1:0]       wp_next;
   logic [QCW-1:0]       n_push;

   assign head      = mem_ff[rp_ff];
   assign not_empty = (cnt_ff != '0);
   assign room2     = (cnt_ff <= QCW'(QDEPTH - 2));
   assign wp_next   = wp_ff + QAW'(1);
   assign n_push    = QCW'(push0) + QCW'(push1);

   // pointers and fill count
   always_comb begin
      wp_in  = wp_ff + QAW'(n_push);
      rp_in  = pop ? rp_ff + QAW'(1) : rp_ff;
      cnt_in = cnt_ff + n_push - QCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push0) begin
         mem_ff[wp_ff] <= cmd0;
      end
      if (push1) begin
         mem_ff[wp_next] <= cmd1;
      end
   end

   `CRPS_ASSERT_IMPLY(a_pop_not_empty, pop, cnt_ff != '0, "pop from empty queue")
   `CRPS_ASSERT_IMPLY(a_push_room, push0 || push1, cnt_ff <= QCW'(QDEPTH - 2),
                      "push without room")
   `CRPS_ASSERT_IMPLY(a_push_order, push1, push0, "second write without first")

endmodule

// ===== src/crps_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module crps_div #(
   parameter int DW = 19
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DW+crps_pkg::QW-1:0]   dividend,
   input  logic [DW-1:0]                divisor,
   output logic                         done,
   output logic [crps_pkg::QW-1:0]      quotient
);
   import crps_pkg::*;

   localparam int MW  = DW + QW;
   localparam int CNW = $clog2(QW + 1);

   logic [DW-1:0]  rem_ff, rem_in;
   logic [QW-1:0]  low_ff, low_in;
   logic [DW-1:0]  dsor_ff, dsor_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic [DW:0]    trial;
   logic           ge;

   assign trial    = {rem_ff, low_ff[QW-1]};
   assign ge       = (trial >= {1'b0, dsor_ff});
   assign done     = busy_ff && (cnt_ff == CNW'(1));
   assign quotient = low_ff;

   // operand load on start, else one shift and subtract step
   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      dsor_in = dsor_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = dividend[MW-1:QW];
         low_in  = dividend[QW-1:0];
         dsor_in = divisor;
         cnt_in  = CNW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? DW'(trial - {1'b0, dsor_ff}) : trial[DW-1:0];
         low_in  = {low_ff[QW-2:0], ge};
         cnt_in  = cnt_ff - CNW'(1);
         busy_in = (cnt_ff != CNW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      dsor_ff <= dsor_in;
   end

endmodule

// ===== src/crps_back.sv =====
// back end: segment count, basis weights and weighted point sum
`timescale 1ns / 1ps
`include "catmull_rom_path_sampler_defines.svh"
module crps_back #(
   parameter int MAX_SEGS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  crps_pkg::cmd_type             cmd,
   input  logic                          cmd_valid,
   output logic                          cmd_pop,
   input  logic [crps_pkg::STEPW-1:0]    step_length,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [39:0]                   rsp_tdata,  // x_out, y_out
   output logic [1:0]                    rsp_tuser,  // first_point, path_end
   output logic                          rsp_tlast   // run_last
);
   import crps_pkg::*;

   localparam int NW   = $clog2(MAX_SEGS + 1);
   localparam int P3W  = 3 * NW;
   localparam int NUMW = P3W + 4;
   localparam int NFW  = NUMW + FRAC + 1;
   localparam int DW   = P3W + 1;
   localparam int MW   = DW + QW;
   localparam int LW   = NW + STEPW;
   localparam int D2W  = 2 * CW + 2;
   localparam int CMPW = (2 * LW > D2W) ? 2 * LW : D2W;
   localparam int WW   = QW + 1;
   localparam int PW   = WW + CW;
   localparam int SW   = PW + 2;
   localparam logic [NW-1:0] NMAX = NW'(MAX_SEGS);
   localparam logic [NW-1:0] NTWO = NW'(2);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_DIFF = 4'd1;
   localparam logic [3:0] ST_SQ   = 4'd2;
   localparam logic [3:0] ST_SUMD = 4'd3;
   localparam logic [3:0] ST_CNT  = 4'd4;
   localparam logic [3:0] ST_POW2 = 4'd5;
   localparam logic [3:0] ST_POW3 = 4'd6;
   localparam logic [3:0] ST_NUM  = 4'd7;
   localparam logic [3:0] ST_PREP = 4'd8;
   localparam logic [3:0] ST_DIV  = 4'd9;
   localparam logic [3:0] ST_WGT  = 4'd10;
   localparam logic [3:0] ST_MUL  = 4'd11;
   localparam logic [3:0] ST_ACC  = 4'd12;
   localparam logic [3:0] ST_EMIT = 4'd13;

   logic [3:0]               state_ff, state_in;
   cmd_type                  cmd_ff;
   logic signed [CW:0]       dx_ff, dy_ff;
   logic [D2W-2:0]           dx2_ff, dy2_ff;
   logic [D2W-1:0]           d2_ff;
   logic [LW-1:0]            len_ff;
   logic [NW-1:0]            n_ff, s_ff;
   logic [2*NW-1:0]          s2_ff, n2_ff;
   logic [P3W-1:0]           s3_ff, s2n_ff, sn2_ff, n3_ff;
   logic signed [NUMW-1:0]   num_ff [4];
   logic                     neg_ff [4];
   logic signed [WW-1:0]     w_ff [4];
   logic signed [PW-1:0]     prx_ff [4];
   logic signed [PW-1:0]     pry_ff [4];
   logic signed [SW-1:0]     ax_ff, ay_ff;
   logic                     out_v_ff, out_v_in;
   coord_type                ox_ff, oy_ff;
   logic                     ofirst_ff, oend_ff, olast_ff;

   logic signed [NUMW-1:0]   s3e, s2ne, sn2e, n3e;
   logic [DW-1:0]            dsor;
   logic signed [NFW-1:0]    nfix [4];
   logic signed [NFW-1:0]    mag [4];
   logic [MW-1:0]            dvd [4];
   logic [QW-1:0]            quo [4];
   logic                     dv_done [4];
   logic                     div_start;
   logic                     out_free;
   logic [CMPW-1:0]          len_sq;
   logic                     cnt_hit;
   logic                     seg_done;
   coord_type                rx, ry;

   // saturate a rounded weighted sum to the coordinate range
   function automatic coord_type sat_round(input logic signed [SW-1:0] acc);
      logic signed [SW-1:0] r;
      coord_type            res;
      r = (acc + SW'(32'sd32768)) >>> FRAC;
      if (r > SW'(COORD_MAX)) begin
         res = COORD_MAX;
      end else if (r < SW'(COORD_MIN)) begin
         res = COORD_MIN;
      end else begin
         res = r[CW-1:0];
      end
      return res;
   endfunction

   assign out_free  = !out_v_ff || rsp_tready;
   assign len_sq    = CMPW'((2 * LW)'(len_ff) * (2 * LW)'(len_ff));
   assign cnt_hit   = (len_sq >= CMPW'(d2_ff)) || (n_ff == NMAX);
   assign seg_done  = cmd_ff.echo || (s_ff == n_ff);
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;
   assign div_start = (state_ff == ST_PREP);

   // sign-extended power terms of the basis numerators, and the divisor 2*n^3
   assign s3e  = NUMW'($signed({1'b0, s3_ff}));
   assign s2ne = NUMW'($signed({1'b0, s2n_ff}));
   assign sn2e = NUMW'($signed({1'b0, sn2_ff}));
   assign n3e  = NUMW'($signed({1'b0, n3_ff}));
   assign dsor = {n3_ff, 1'b0};

   // divider operands: signed numerator scaled by 2^FRAC plus n^3, floored by 2*n^3, magnitude form
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         nfix[i] = (NFW'(num_ff[i]) <<< FRAC) + NFW'($signed({1'b0, n3_ff}));
         mag[i]  = nfix[i][NFW-1] ?
                   (-nfix[i] + NFW'($signed({1'b0, dsor})) - NFW'(1)) : nfix[i];
         dvd[i]  = mag[i][MW-1:0];
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_div
      crps_div #(.DW(DW)) u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (div_start),
         .dividend (dvd[g]),
         .divisor  (dsor),
         .done     (dv_done[g]),
         .quotient (quo[g])
      );
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = cmd.echo ? ST_EMIT : ST_DIFF;
            end
         end
         ST_DIFF: state_in = ST_SQ;
         ST_SQ:   state_in = ST_SUMD;
         ST_SUMD: state_in = ST_CNT;
         ST_CNT: begin
            if (cnt_hit) begin
               state_in = ST_POW2;
            end
         end
         ST_POW2: state_in = ST_POW3;
         ST_POW3: state_in = ST_NUM;
         ST_NUM:  state_in = ST_PREP;
         ST_PREP: state_in = ST_DIV;
         ST_DIV: begin
            if (dv_done[0]) begin
               state_in = ST_WGT;
            end
         end
         ST_WGT:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_ACC;
         ST_ACC:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = seg_done ? ST_IDLE : ST_POW2;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            cmd_ff <= cmd;
         end
         ST_DIFF: begin
            dx_ff <= (CW + 1)'($signed(cmd_ff.px[2])) - (CW + 1)'($signed(cmd_ff.px[1]));
            dy_ff <= (CW + 1)'($signed(cmd_ff.py[2])) - (CW + 1)'($signed(cmd_ff.py[1]));
         end
         ST_SQ: begin
            dx2_ff <= (D2W - 1)'(dx_ff * dx_ff);
            dy2_ff <= (D2W - 1)'(dy_ff * dy_ff);
         end
         ST_SUMD: begin
            d2_ff  <= D2W'(dx2_ff) + D2W'(dy2_ff);
            n_ff   <= NTWO;
            len_ff <= LW'({step_length, 1'b0});
         end
         ST_CNT: begin
            if (cnt_hit) begin
               s_ff <= NW'(1);
            end else begin
               n_ff   <= n_ff + NW'(1);
               len_ff <= len_ff + LW'(step_length);
            end
         end
         ST_POW2: begin
            s2_ff <= (2 * NW)'(s_ff) * (2 * NW)'(s_ff);
            n2_ff <= (2 * NW)'(n_ff) * (2 * NW)'(n_ff);
         end
         ST_POW3: begin
            s3_ff  <= P3W'(s2_ff) * P3W'(s_ff);
            s2n_ff <= P3W'(s2_ff) * P3W'(n_ff);
            sn2_ff <= P3W'(s_ff) * P3W'(n2_ff);
            n3_ff  <= P3W'(n2_ff) * P3W'(n_ff);
         end
         ST_NUM: begin
            num_ff[0] <= -s3e + (s2ne <<< 1) - sn2e;
            num_ff[1] <= (s3e <<< 1) + s3e - (s2ne <<< 2) - s2ne + (n3e <<< 1);
            num_ff[2] <= -(s3e <<< 1) - s3e + (s2ne <<< 2) + sn2e;
            num_ff[3] <= s3e - s2ne;
         end
         ST_PREP: begin
            for (int i = 0; i < 4; i++) begin
               neg_ff[i] <= nfix[i][NFW-1];
            end
         end
         ST_DIV: begin
         end
         ST_WGT: begin
            for (int i = 0; i < 4; i++) begin
               w_ff[i] <= neg_ff[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
            end
         end
         ST_MUL: begin
            for (int i = 0; i < 4; i++) begin
               prx_ff[i] <= PW'(w_ff[i]) * PW'($signed(cmd_ff.px[i]));
               pry_ff[i] <= PW'(w_ff[i]) * PW'($signed(cmd_ff.py[i]));
            end
         end
         ST_ACC: begin
            ax_ff <= SW'(prx_ff[0]) + SW'(prx_ff[1]) + SW'(prx_ff[2]) + SW'(prx_ff[3]);
            ay_ff <= SW'(pry_ff[0]) + SW'(pry_ff[1]) + SW'(pry_ff[2]) + SW'(pry_ff[3]);
         end
         ST_EMIT: begin
            if (out_free && !seg_done) begin
               s_ff <= s_ff + NW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // output stage
   assign rx = cmd_ff.echo ? cmd_ff.px[2] : sat_round(ax_ff);
   assign ry = cmd_ff.echo ? cmd_ff.py[2] : sat_round(ay_ff);

   always_comb begin
      out_v_in = out_v_ff;
      if (rsp_tready) begin
         out_v_in = 1'b0;
      end
      if ((state_ff == ST_EMIT) && out_free) begin
         out_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_EMIT) && out_free) begin
         ox_ff     <= rx;
         oy_ff     <= ry;
         ofirst_ff <= cmd_ff.first;
         oend_ff   <= cmd_ff.path_end && seg_done;
         olast_ff  <= cmd_ff.run_last && seg_done;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {oy_ff, ox_ff};
   assign rsp_tuser  = {oend_ff, ofirst_ff};
   assign rsp_tlast  = olast_ff;

   `CRPS_ASSERT_IMPLY(a_sample_range, (state_ff == ST_EMIT) && !cmd_ff.echo,
                      (s_ff >= NW'(1)) && (s_ff <= n_ff), "sample index out of range")
   `CRPS_ASSERT_IMPLY(a_seg_range, (state_ff == ST_POW2) || (state_ff == ST_MUL),
                      (n_ff >= NTWO) && (n_ff <= NMAX), "segment count out of range")

endmodule

// ===== src/catmull_rom_path_sampler.sv =====
// top level of the Catmull-Rom path sampler
// an echo goes from the queue through the emit state to the output; a segment first
// runs the diff, square, sum and count states (counts 2..MAX_SEGS), then each sample
// runs power, numerator, divide, weight, multiply, accumulate and emit states.
// waypoints are taken while the command queue has room for two entries.
// reset is synchronous and active high; it clears history, queue and step_length to 128.
`timescale 1ns / 1ps
module catmull_rom_path_sampler #(
   parameter int MAX_SEGS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // x_coord, y_coord
   input  logic        req_tlast,   // last_waypoint
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // x_out, y_out
   output logic [1:0]  rsp_tuser,   // first_point, path_end
   output logic        rsp_tlast,   // run_last
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata
);
   import crps_pkg::*;

   logic [STEPW-1:0] step_ff;
   logic             push0, push1, pop, not_empty, room2;
   cmd_type          cmd0, cmd1, head;

   // step length register
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (csr_we) begin
         step_ff <= csr_wdata;
      end
   end

   crps_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .x_coord       (req_tdata[19:0]),
      .y_coord       (req_tdata[39:20]),
      .last_waypoint (req_tlast),
      .q_room        (room2),
      .push0         (push0),
      .push1         (push1),
      .cmd0          (cmd0),
      .cmd1          (cmd1)
   );

   crps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push0     (push0),
      .push1     (push1),
      .cmd0      (cmd0),
      .cmd1      (cmd1),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .room2     (room2)
   );

   crps_back #(.MAX_SEGS(MAX_SEGS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd         (head),
      .cmd_valid   (not_empty),
      .cmd_pop     (pop),
      .step_length (step_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
